// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the priority task scheduler.
// No dependencies; imported by every module of the block.
package pts_pkg;

  localparam int PRIO_W    = 8;
  localparam int DELAY_W   = 32;
  localparam int HANDLE_W  = 3;
  localparam int OUT_TICK_W = 32;
  localparam int FUNC_W    = 3;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE   = 3'd0,
    FN_DELAY    = 3'd1,
    FN_SUSPEND  = 3'd2,
    FN_ACTIVATE = 3'd3,
    FN_TICK     = 3'd4
  } func_e_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_WAITING = 2'd2,
    ST_SUSP    = 2'd3
  } run_state_t;

  // One-cycle command broadcast to every cell; sel picks the target, tick goes to all.
  typedef struct packed {
    logic              create;
    logic              delay;
    logic              suspend;
    logic              activate;
    logic              tick;
    logic              make_run;
    logic              start_susp;
    logic [PRIO_W-1:0] prio;
    logic [DELAY_W-1:0] delay_ticks;
  } cell_cmd_t;

  // Best candidate so far, handed from cell to cell during the scan.
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
  } tok_t;

endpackage

// ===== rtl/priority_task_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Priority task scheduler, top level: event decode, sequencer, chain of task
// cells and result register. Depends on pts_pkg and pts_cell.
//
// One event transaction is taken on the s_ side when s_tready is high; the
// event is applied to the task table in that same cycle, then a best-task
// token walks the chain of MAX_TASKS cells, one cell per cycle, and the
// S_FIN state then commits the selection and loads the result register;
// an unknown event code skips the walk and goes straight to S_FIN. The
// result waits in its own register, so the next event can be taken while
// the result is still not taken downstream; only a finished selection with
// the result register still full holds the block. Ties go to the lowest
// task index. There is no clearing pass after reset: slots beyond the
// created count are never read.
module priority_task_scheduler_unit
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = 8,
  parameter int TICK_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [7:0] task_priority, [8] start_suspended, [40:9] delay_ticks,
  // [43:41] task_id, [47:44] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  // [2:0] func
  input  logic [FUNC_W-1:0]   s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] create_ok, [3:1] new_handle, [6:4] cur_task, [7] current_valid,
  // [8] switched, [40:9] tick_count, [47:41] zero
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
  localparam int SC_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  // ---------------- input fields ----------------
  logic [FUNC_W-1:0]   in_func;
  logic [PRIO_W-1:0]   in_prio;
  logic                in_susp;
  logic [DELAY_W-1:0]  in_delay;
  logic [HANDLE_W-1:0] in_id;

  assign in_func  = s_tuser;
  assign in_prio  = s_tdata[7:0];
  assign in_susp  = s_tdata[8];
  assign in_delay = s_tdata[40:9];
  assign in_id    = s_tdata[43:41];

  // ---------------- control state ----------------
  state_t               state;
  logic [SC_W-1:0]      scan_cnt;
  logic [CNT_W-1:0]     task_total;
  logic [IDX_W-1:0]     running_index;
  logic                 running_valid;
  logic [TICK_BITS-1:0] global_ticks;
  logic                 sched;      // event was recognized, selection runs
  logic                 create_ok;
  logic [HANDLE_W-1:0]  new_handle;

  logic accept;
  logic fire;
  logic table_free;
  logic id_ok;
  logic known;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign fire       = (state == S_FIN) && (!m_tvalid || m_tready);
  assign table_free = (task_total < CNT_W'(MAX_TASKS));
  assign id_ok      = (CMP_W'(in_id) < CMP_W'(task_total));

  always_comb begin
    case (in_func)
      FN_CREATE, FN_DELAY, FN_SUSPEND, FN_ACTIVATE, FN_TICK: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // ---------------- cell chain ----------------
  tok_t             tok [0:MAX_TASKS];
  logic [IDX_W-1:0] tidx [0:MAX_TASKS];
  logic             best_found;
  logic [IDX_W-1:0] best_idx;

  assign tok[0]     = '0;
  assign tidx[0]    = '0;
  assign best_found = tok[MAX_TASKS].found;
  assign best_idx   = tidx[MAX_TASKS];

  // selection outcome, used at the commit cycle
  logic             same_task;
  logic             cur_valid_n;
  logic [IDX_W-1:0] cur_idx_n;
  logic             switched_n;

  assign same_task = running_valid && (running_index == best_idx);

  always_comb begin
    cur_valid_n = running_valid;
    cur_idx_n   = running_index;
    switched_n  = 1'b0;
    if (sched) begin
      if (!best_found) begin
        cur_valid_n = 1'b0;
        cur_idx_n   = '0;
        switched_n  = running_valid;
      end else if (!same_task) begin
        cur_valid_n = 1'b1;
        cur_idx_n   = best_idx;
        switched_n  = 1'b1;
      end
    end
  end

  // command broadcast and target slot
  cell_cmd_t        cmd;
  logic [CMP_W-1:0] target;

  always_comb begin
    cmd             = '0;
    cmd.start_susp  = in_susp;
    cmd.prio        = in_prio;
    cmd.delay_ticks = in_delay;
    target          = CMP_W'(task_total);
    if (accept) begin
      case (in_func)
        FN_CREATE: begin
          cmd.create = table_free;
          target     = CMP_W'(task_total);
        end
        FN_DELAY: begin
          cmd.delay = running_valid;
          target    = CMP_W'(running_index);
        end
        FN_SUSPEND: begin
          cmd.suspend = running_valid;
          target      = CMP_W'(running_index);
        end
        FN_ACTIVATE: begin
          cmd.activate = id_ok;
          target       = CMP_W'(in_id);
        end
        FN_TICK: begin
          cmd.tick = 1'b1;
        end
        default: begin
          cmd = cmd;
        end
      endcase
    end else if (fire) begin
      // the new current task gets its running mark
      cmd.make_run = sched && best_found && !same_task;
      target       = CMP_W'(best_idx);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      logic hit;
      logic created;
      assign hit     = (target == CMP_W'(gi));
      assign created = (task_total > CNT_W'(gi));
      pts_cell #(
        .IDX_W (IDX_W),
        .IDX   (gi)
      ) u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .sel     (hit),
        .created (created),
        .tok_in  (tok[gi]),
        .idx_in  (tidx[gi]),
        .tok_out (tok[gi+1]),
        .idx_out (tidx[gi+1])
      );
    end
  endgenerate

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_cnt      <= '0;
      task_total    <= '0;
      running_index <= '0;
      running_valid <= 1'b0;
      global_ticks  <= '0;
      sched         <= 1'b0;
      create_ok     <= 1'b0;
      new_handle    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            sched      <= known;
            create_ok  <= 1'b0;
            new_handle <= '0;
            scan_cnt   <= '0;
            if (in_func == FN_CREATE && table_free) begin
              create_ok  <= 1'b1;
              new_handle <= HANDLE_W'(task_total);
              task_total <= task_total + 1'b1;
            end
            if (in_func == FN_TICK) begin
              global_ticks <= global_ticks + 1'b1;
            end
            state <= known ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SC_W'(MAX_TASKS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fire) begin
            running_valid <= cur_valid_n;
            running_index <= cur_idx_n;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata[0]     <= create_ok;
      m_tdata[3:1]   <= new_handle;
      m_tdata[6:4]   <= HANDLE_W'(cur_idx_n);
      m_tdata[7]     <= cur_valid_n;
      m_tdata[8]     <= switched_n;
      m_tdata[40:9]  <= OUT_TICK_W'(global_ticks);
      m_tdata[47:41] <= '0;
    end
  end

endmodule

// ===== rtl/pts_cell.sv =====
`timescale 1ns / 1ps
// One task slot: priority, run state and wait counter, plus one stage of the
// best-task token chain. Depends on pts_pkg.
module pts_cell
  import pts_pkg::*;
#(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic             sel,
  input  logic             created,
  input  tok_t             tok_in,
  input  logic [IDX_W-1:0] idx_in,
  output tok_t             tok_out,
  output logic [IDX_W-1:0] idx_out
);

  logic [PRIO_W-1:0]  prio;
  run_state_t         st;
  logic [DELAY_W-1:0] cnt;
  logic [DELAY_W-1:0] cnt_dec;
  logic               eligible;

  assign cnt_dec  = cnt - 1'b1;
  assign eligible = created && (st == ST_READY || st == ST_RUNNING) &&
                    (!tok_in.found || prio > tok_in.prio);

  always_ff @(posedge clk) begin
    if (sel && cmd.create) begin
      prio <= cmd.prio;
      cnt  <= '0;
      st   <= cmd.start_susp ? ST_SUSP : ST_READY;
    end else if (sel && cmd.delay) begin
      st  <= ST_WAITING;
      cnt <= (cmd.delay_ticks == '0) ? DELAY_W'(1) : cmd.delay_ticks;
    end else if (sel && cmd.suspend) begin
      st <= ST_SUSP;
    end else if (sel && cmd.activate) begin
      st <= ST_READY;
    end else if (sel && cmd.make_run) begin
      st <= ST_RUNNING;
    end else if (cmd.tick && created && st == ST_WAITING) begin
      cnt <= cnt_dec;
      if (cnt_dec == '0) begin
        st <= ST_READY;
      end
    end
  end

  // token stage: pass the better of the incoming candidate and this slot
  always_ff @(posedge clk) begin
    if (eligible) begin
      tok_out.found <= 1'b1;
      tok_out.prio  <= prio;
      idx_out       <= IDX_W'(IDX);
    end else begin
      tok_out <= tok_in;
      idx_out <= idx_in;
    end
  end

endmodule

// ===== rtl/pts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the priority task scheduler, bound to the top level.
// Depends on pts_pkg and priority_task_scheduler_unit.
module pts_checker
  import pts_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one event at a time: no transaction right after one was taken
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("event taken while busy");

  // no current task reports index zero
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7] || m_tdata[6:4] == '0))
    else $error("task index nonzero with no current task");

  // failed or absent create reports handle zero
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[3:1] == '0))
    else $error("new_handle nonzero without create_ok");

endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/priority_task_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for priority_task_scheduler_unit: event transactions in, one
// outcome transaction out per event, checked against an in-bench scheduler model.
// Depends on pts_pkg and the scheduler RTL.
module priority_task_scheduler_unit_tb;
  import pts_pkg::*;

  localparam int NUM_TASKS    = 8;
  localparam int FUNC_CODES   = 1 << FUNC_W;   // codes past FN_TICK are unknown events
  localparam int STALL_LIMIT  = 1000;          // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 40;            // cycles to run on after the last owed outcome is checked
  localparam int REPORT_MAX   = 10;

  // One scheduler outcome, as carried on m_tdata.
  typedef struct packed {
    logic                  create_ok;
    logic [HANDLE_W-1:0]   new_handle;
    logic [HANDLE_W-1:0]   cur_task;
    logic                  current_valid;
    logic                  switched;
    logic [OUT_TICK_W-1:0] tick_count;
  } outcome_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [FUNC_W-1:0]   s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  priority_task_scheduler_unit #(
    .MAX_TASKS(NUM_TASKS),
    .TICK_BITS(OUT_TICK_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler model: task table, current task and tick counter, updated once
  // per accepted event transaction.
  // ---------------------------------------------------------------------------
  logic [3:0]            n_created;
  logic [PRIO_W-1:0]     task_prio [NUM_TASKS];
  run_state_t            task_state[NUM_TASKS];
  logic [DELAY_W-1:0]    task_wait [NUM_TASKS];
  logic [HANDLE_W-1:0]   cur_idx;
  logic                  cur_valid;
  logic [OUT_TICK_W-1:0] tick_ctr;

  outcome_t outcome_q[$];   // outcomes still owed by the block, oldest first
  int       mismatches;
  int       idle_cycles;
  bit       no_gaps;        // both sides run back to back while set

  // Highest-priority ready/running task, lowest index on ties; returns 1 on a switch.
  function automatic logic reselect();
    logic                found;
    logic [HANDLE_W-1:0] best;
    logic [PRIO_W-1:0]   best_prio;
    found     = 1'b0;
    best      = '0;
    best_prio = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (i < n_created && (task_state[i] == ST_READY || task_state[i] == ST_RUNNING) &&
          (!found || task_prio[i] > best_prio)) begin
        found     = 1'b1;
        best      = i[HANDLE_W-1:0];
        best_prio = task_prio[i];
      end
    end
    if (!found) begin
      reselect  = cur_valid;
      cur_valid = 1'b0;
      cur_idx   = '0;
      return reselect;
    end
    if (cur_valid && cur_idx == best) return 1'b0;
    cur_idx          = best;
    cur_valid        = 1'b1;
    task_state[best] = ST_RUNNING;
    return 1'b1;
  endfunction

  function automatic outcome_t apply_event(input logic [FUNC_W-1:0] fn,
                                           input logic [PRIO_W-1:0] prio,
                                           input logic susp,
                                           input logic [DELAY_W-1:0] delay,
                                           input logic [HANDLE_W-1:0] id);
    outcome_t res;
    res = '0;
    case (fn)
      FN_CREATE: begin
        if (n_created < NUM_TASKS) begin
          task_prio[n_created[HANDLE_W-1:0]]  = prio;
          task_wait[n_created[HANDLE_W-1:0]]  = '0;
          task_state[n_created[HANDLE_W-1:0]] = susp ? ST_SUSP : ST_READY;
          res.new_handle = n_created[HANDLE_W-1:0];
          res.create_ok  = 1'b1;
          n_created++;
        end
        res.switched = reselect();
      end
      FN_DELAY: begin
        if (cur_valid) begin
          task_state[cur_idx] = ST_WAITING;
          task_wait[cur_idx]  = (delay == '0) ? DELAY_W'(1) : delay;   // zero delay means one tick
        end
        res.switched = reselect();
      end
      FN_SUSPEND: begin
        if (cur_valid) task_state[cur_idx] = ST_SUSP;
        res.switched = reselect();
      end
      FN_ACTIVATE: begin
        if (id < n_created) task_state[id] = ST_READY;   // unknown handle: ignored
        res.switched = reselect();
      end
      FN_TICK: begin
        tick_ctr++;
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (i < n_created && task_state[i] == ST_WAITING) begin
            task_wait[i]--;
            if (task_wait[i] == '0) task_state[i] = ST_READY;
          end
        end
        res.switched = reselect();
      end
      default: ;   // unknown code: no change, no selection
    endcase
    res.cur_task      = cur_valid ? cur_idx : '0;
    res.current_valid = cur_valid;
    res.tick_count    = tick_ctr;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Event side: one transaction per call, random gap before it. s_tvalid stays
  // high across back-to-back transactions so it is never dropped and raised in
  // one step.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [FUNC_W-1:0] fn,
                            input logic [PRIO_W-1:0] prio = '0,
                            input logic susp = 1'b0,
                            input logic [DELAY_W-1:0] delay = '0,
                            input logic [HANDLE_W-1:0] id = '0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {{(S_DATA_W - PRIO_W - 1 - DELAY_W - HANDLE_W){1'b0}}, id, delay, susp, prio};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    outcome_q.push_back(apply_event(fn, prio, susp, delay, id));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Outcome side: random stall before each transaction, then check against the
  // oldest owed outcome.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.create_ok     = m_tdata[0];
      got.new_handle    = m_tdata[3:1];
      got.cur_task      = m_tdata[6:4];
      got.current_valid = m_tdata[7];
      got.switched      = m_tdata[8];
      got.tick_count    = m_tdata[40:9];
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected outcome transaction 0x%0h", $realtime, m_tdata);
      end else begin
        want = outcome_q.pop_front();
        if (got.create_ok != want.create_ok)
          note_mismatch("create_ok", 32'(want.create_ok), 32'(got.create_ok));
        if (got.new_handle != want.new_handle)
          note_mismatch("new_handle", 32'(want.new_handle), 32'(got.new_handle));
        if (got.cur_task != want.cur_task)
          note_mismatch("cur_task", 32'(want.cur_task), 32'(got.cur_task));
        if (got.current_valid != want.current_valid)
          note_mismatch("current_valid", 32'(want.current_valid), 32'(got.current_valid));
        if (got.switched != want.switched)
          note_mismatch("switched", 32'(want.switched), 32'(got.switched));
        if (got.tick_count != want.tick_count)
          note_mismatch("tick_count", want.tick_count, got.tick_count);
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: delay/suspend with nothing current, activate of an unknown
  // handle, a tick with no tasks, unknown event codes.
  task automatic test_empty_table();
    send_event(FN_DELAY, '0, 1'b0, '0);
    send_event(FN_SUSPEND);
    send_event(FN_ACTIVATE, '0, 1'b0, '0, HANDLE_W'(NUM_TASKS - 1));
    send_event(FN_TICK);
    send_event(FUNC_W'(FN_TICK + 1));
    send_event(FUNC_W'(FUNC_CODES - 1));
  endtask

  // Creation, preemption, tie on priority, zero delay, wakeup on tick and a
  // create into a full table.
  task automatic test_create_and_preempt();
    send_event(FN_CREATE, 8'h00, 1'b0);                       // first task runs
    send_event(FN_CREATE, 8'h00, 1'b1);                       // created suspended
    send_event(FN_CREATE, 8'hFF, 1'b0);                       // preempts
    send_event(FN_CREATE, 8'hFF, 1'b0);                       // tie, lower index keeps it
    send_event(FN_ACTIVATE, '0, 1'b0, '0, HANDLE_W'(NUM_TASKS - 1)); // handle not created yet
    send_event(FN_ACTIVATE, '0, 1'b0, '0, 3'd1);
    send_event(FN_DELAY, '0, 1'b0, '0);                       // zero delay -> one tick
    send_event(FN_TICK);                                      // waiter back, wins the tie
    send_event(FN_SUSPEND);
    send_event(FN_CREATE, 8'hAA, 1'b0);
    send_event(FN_CREATE, 8'h55, 1'b0);
    send_event(FN_CREATE, 8'h80, 1'b1);
    send_event(FN_CREATE, 8'h7F, 1'b0);                       // table now full
    send_event(FN_CREATE, PRIO_W'($urandom), 1'($urandom_range(0, 1)));  // no free entry
  endtask

  // Park every runnable task on a delay that never expires until none is current.
  task automatic test_nothing_ready();
    for (int i = 0; i < NUM_TASKS && cur_valid; i++)
      send_event(FN_DELAY, '0, 1'b0, {DELAY_W{1'b1}});
    send_event(FN_TICK);
    send_event(FN_ACTIVATE, '0, 1'b0, '0, 3'd5);
  endtask

  // Random event mix weighted toward ticks, short delays and activations so
  // that tasks keep cycling through waiting, suspended and running.
  task automatic test_random_events(input int count);
    int                  pick;
    logic [DELAY_W-1:0]  delay;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 20)      delay = $urandom;
      else if (pick < 40) delay = $urandom_range(5, 40);
      else                delay = $urandom_range(0, 4);
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_event(FN_TICK);
      else if (pick < 60)
        send_event(FN_DELAY, PRIO_W'($urandom), 1'($urandom_range(0, 1)), delay,
                   HANDLE_W'($urandom_range(0, 7)));
      else if (pick < 70)
        send_event(FN_SUSPEND);
      else if (pick < 92)
        send_event(FN_ACTIVATE, PRIO_W'($urandom), 1'($urandom_range(0, 1)), $urandom,
                   HANDLE_W'($urandom_range(0, NUM_TASKS - 1)));
      else if (pick < 97)
        send_event(FN_CREATE, PRIO_W'($urandom), 1'($urandom_range(0, 1)), $urandom,
                   HANDLE_W'($urandom_range(0, 7)));
      else
        send_event(FUNC_W'($urandom_range(FN_TICK + 1, FUNC_CODES - 1)), PRIO_W'($urandom),
                   1'($urandom_range(0, 1)), $urandom, HANDLE_W'($urandom_range(0, 7)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    no_gaps    = 1'b0;
    n_created  = '0;
    cur_idx    = '0;
    cur_valid  = 1'b0;
    tick_ctr   = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      task_prio[i]  = '0;
      task_state[i] = ST_READY;
      task_wait[i]  = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_create_and_preempt();
    test_nothing_ready();
    test_random_events(420);

    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
